### rtl/core/lru_keyed_handle_cache_core_assert.svh
// Assertion macros used by the handle cache checker.
`ifndef LRU_KEYED_HANDLE_CACHE_CORE_ASSERT_SVH
`define LRU_KEYED_HANDLE_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LKHC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication; cons may open with a further delay.
`define LKHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

### rtl/core/lkhc_pkg.sv
// Types and constants of the keyed handle cache.
package lkhc_pkg;

	localparam int LKHC_ENTRIES = 128;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NOP    = 2'd3
	} lkhc_kind_t;

	typedef struct packed {
		lkhc_kind_t  kind;
		logic        sheet_select;
		logic [15:0] sprite_code;
		logic [2:0]  transform_kind;
		logic [31:0] new_handle;
	} lkhc_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] hit_handle;
		logic        evicted;
		logic [31:0] evicted_handle;
	} lkhc_rsp_t;

	// controls broadcast from the sequencer to every cell
	typedef struct packed {
		logic capture;     // latch match / rank-zero flags
		logic pick_match;  // pick highest-index match
		logic pick_zero;   // pick lowest-index rank-zero slot
		logic age;         // promote winner, age ranks above sel_rank
		logic fill;        // write winner with the stored item
		logic clear;       // invalidate all
	} lkhc_ctl_t;

	// OR-gather bus running along the cell row
	typedef struct packed {
		logic        win;
		logic        valid;
		logic [31:0] handle;
	} lkhc_gather_t;

endpackage

### rtl/core/lru_keyed_handle_cache_core.sv
// Top level of the keyed handle cache: sequencer, result register and the cell row.
//
// Fully associative LRU cache of ENTRIES slots built as a row of cells. An
// item is taken when start is high and busy is low; busy then stays high
// through the pick, gather and update states, and the result appears on
// rsp in the cycle after the update, marked by done for exactly one cycle.
// The receiver cannot stall: the result must be taken in that cycle. A new
// item may be accepted in the same cycle that done is high, but none is
// taken before the last has passed its update, whatever the kind. Steps:
// key compare into every cell (acceptance cycle), priority pick along the
// cell row, gather of the winner's handle, rank and valid along the row,
// and the rank/fill update; the pick and the gather walk the whole row.
// No clearing pass follows reset; key and handle storage is never cleared.
module lru_keyed_handle_cache_core
	import lkhc_pkg::*;
#(
	parameter int ENTRIES = LKHC_ENTRIES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  lkhc_req_t req,
	output logic      done,
	output lkhc_rsp_t rsp
);

	localparam int RANK_W = $clog2(ENTRIES);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PICK   = 4'b0010,
		ST_GATHER = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	lkhc_req_t         cmd_q;
	lkhc_ctl_t         ctl;
	logic              accept;
	logic              found_q;
	logic              sel_valid_q;
	logic [31:0]       sel_handle_q;
	logic [RANK_W-1:0] sel_rank_q;
	logic              done_q;
	lkhc_rsp_t         rsp_q;
	lkhc_rsp_t         rsp_d;

	// row links, index i sits between cell i-1 and cell i
	logic              hi_c [ENTRIES+1];
	logic              lo_c [ENTRIES+1];
	lkhc_gather_t      g_c  [ENTRIES+1];
	logic [RANK_W-1:0] r_c  [ENTRIES+1];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_PICK;
			ST_PICK:   state_d = ST_GATHER;
			ST_GATHER: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// broadcast controls; found_q is only ever set for a lookup hit or an insert
	always_comb begin
		ctl.capture    = accept;
		ctl.pick_match = (state_q == ST_PICK) && (cmd_q.kind == KIND_LOOKUP);
		ctl.pick_zero  = (state_q == ST_PICK) && (cmd_q.kind == KIND_INSERT);
		ctl.age        = (state_q == ST_UPDATE) && found_q;
		ctl.fill       = (state_q == ST_UPDATE) && found_q && (cmd_q.kind == KIND_INSERT);
		ctl.clear      = (state_q == ST_UPDATE) && (cmd_q.kind == KIND_CLEAR);
	end

	// result: fields not owned by the operation stay zero
	always_comb begin
		rsp_d = '0;
		unique case (cmd_q.kind)
			KIND_LOOKUP: begin
				rsp_d.hit        = found_q;
				rsp_d.hit_handle = {32{found_q}} & sel_handle_q;
			end
			KIND_INSERT: begin
				rsp_d.evicted        = sel_valid_q;
				rsp_d.evicted_handle = {32{sel_valid_q}} & sel_handle_q;
			end
			KIND_CLEAR, KIND_NOP: rsp_d = '0;
			default:              rsp_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPDATE);
			// cells keep the last winner through a clear or no-op, so mask it
			if (state_q == ST_GATHER) begin
				found_q <= g_c[ENTRIES].win
					&& ((cmd_q.kind == KIND_LOOKUP) || (cmd_q.kind == KIND_INSERT));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
		if (state_q == ST_GATHER) begin
			sel_valid_q  <= g_c[ENTRIES].valid;
			sel_handle_q <= g_c[ENTRIES].handle;
			sel_rank_q   <= r_c[ENTRIES];
		end
		if (state_q == ST_UPDATE) begin
			rsp_q <= rsp_d;
		end
	end

	assign hi_c[ENTRIES] = 1'b0;
	assign lo_c[0]       = 1'b0;
	assign g_c[0]        = '0;
	assign r_c[0]        = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkhc_cell #(
			.ENTRIES(ENTRIES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.req      (req),
			.cmd      (cmd_q),
			.sel_rank (sel_rank_q),
			.hi_in    (hi_c[i+1]),
			.hi_out   (hi_c[i]),
			.lo_in    (lo_c[i]),
			.lo_out   (lo_c[i+1]),
			.gin      (g_c[i]),
			.gout     (g_c[i+1]),
			.rin      (r_c[i]),
			.rout     (r_c[i+1])
		);
	end

endmodule

### rtl/core/lkhc_cell.sv
// One slot of the cache: key, handle, valid, rank and its links to the neighbours.
module lkhc_cell
	import lkhc_pkg::*;
#(
	parameter int ENTRIES = LKHC_ENTRIES,
	localparam int RANK_W = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lkhc_ctl_t         ctl,
	input  lkhc_req_t         req,
	input  lkhc_req_t         cmd,
	input  logic [RANK_W-1:0] sel_rank,
	input  logic              hi_in,
	output logic              hi_out,
	input  logic              lo_in,
	output logic              lo_out,
	input  lkhc_gather_t      gin,
	output lkhc_gather_t      gout,
	input  logic [RANK_W-1:0] rin,
	output logic [RANK_W-1:0] rout
);

	localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(ENTRIES - 1);

	logic              valid_q;
	logic [RANK_W-1:0] rank_q;
	logic              sheet_q;
	logic [15:0]       code_q;
	logic [2:0]        xform_q;
	logic [31:0]       handle_q;
	logic              match_q;
	logic              zero_q;
	logic              win_q;

	// priority links: matches above, rank-zero slots below
	assign hi_out = hi_in | match_q;
	assign lo_out = lo_in | zero_q;

	assign gout.win    = gin.win | win_q;
	assign gout.valid  = gin.valid | (win_q & valid_q);
	assign gout.handle = gin.handle | ({32{win_q}} & handle_q);
	assign rout        = rin | ({RANK_W{win_q}} & rank_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			zero_q  <= 1'b0;
			win_q   <= 1'b0;
		end else begin
			if (ctl.capture) begin
				match_q <= valid_q && (sheet_q == req.sheet_select)
					&& (code_q == req.sprite_code) && (xform_q == req.transform_kind);
				zero_q  <= (rank_q == '0);
			end
			if (ctl.pick_match || ctl.pick_zero) begin
				win_q <= (ctl.pick_match & match_q & ~hi_in)
					| (ctl.pick_zero & zero_q & ~lo_in);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (ctl.fill && win_q) begin
				valid_q <= 1'b1;
			end
			if (ctl.age) begin
				if (win_q) begin
					rank_q <= TOP_RANK;
				end else if (rank_q > sel_rank) begin
					rank_q <= rank_q - RANK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fill && win_q) begin
			sheet_q  <= cmd.sheet_select;
			code_q   <= cmd.sprite_code;
			xform_q  <= cmd.transform_kind;
			handle_q <= cmd.new_handle;
		end
	end

endmodule

### rtl/core/lkhc_checker.sv
// Port-level checks of the keyed handle cache, bound to the top level.
`include "lru_keyed_handle_cache_core_assert.svh"

module lkhc_checker
	import lkhc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input lkhc_rsp_t rsp
);

	`LKHC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after item taken")
	`LKHC_ASSERT_NEXT(a_accept_done, start && !busy, ##3 done, "no result four cycles after item")
	`LKHC_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")
	`LKHC_ASSERT_SAME(a_hit_evict, done, !(rsp.hit && rsp.evicted), "hit and eviction together")
	`LKHC_ASSERT_SAME(a_miss_zero, done && !rsp.hit, rsp.hit_handle == 32'd0, "handle on a miss")

endmodule

bind lru_keyed_handle_cache_core lkhc_checker u_lkhc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
